// File: sv/lsb_message_extractor_defines.svh
// Assertion macros for the LSB message extractor.
`ifndef LSB_MESSAGE_EXTRACTOR_DEFINES_SVH
`define LSB_MESSAGE_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LME_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("lme assertion failed");
`define LME_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lme assertion failed");
`else
`define LME_ASSERT(lbl, clk, rstn, prop)
`define LME_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/lme_pkg.sv
// Shared types and constants of the LSB message extractor.
package lme_pkg;

  localparam logic [31:0] CheckInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CheckPoly = 32'h04C1_1DB7;
  localparam int unsigned CheckSteps = 8;

  localparam logic [4:0] CharLastBit  = 5'd7;
  localparam logic [4:0] CheckLastBit = 5'd31;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic {
    KindChar   = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoMsg    = 2'd1,
    StBadCheck = 2'd2
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_value;
    status_e    status;
    logic       run_end;
  } result_t;

  // Results produced by one input beat, packed toward the first slot.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: sv/lme_result_fifo.sv
// Result queue that takes up to two results per cycle and emits one.
`include "lsb_message_extractor_defines.svh"

module lme_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lme_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lme_pkg::result_t head_o
);

  lme_pkg::result_t                 mem_q [lme_pkg::FifoDepth];
  logic [lme_pkg::PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [lme_pkg::PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [lme_pkg::CntW-1:0]         count_q, count_d;
  logic [lme_pkg::PtrW-1:0]         wr_ptr_nxt;
  logic                             pop;

  localparam logic [lme_pkg::CntW-1:0] Depth = lme_pkg::CntW'(lme_pkg::FifoDepth);

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  // keep room for a two-result beat
  assign room_o      = (count_q <= Depth - lme_pkg::CntW'(2));
  assign wr_ptr_nxt  = wr_ptr_q + lme_pkg::PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + lme_pkg::PtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + lme_pkg::PtrW'(pop);
    count_d  = count_q + lme_pkg::CntW'(push_i.cnt) - lme_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

  `LME_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= Depth)
  `LME_ASSERT(a_push_fits, clk_i, rst_ni,
              (push_i.cnt != 2'd0) |-> (count_q + lme_pkg::CntW'(push_i.cnt) <= Depth))
  `LME_ASSERT(a_pop_drains, clk_i, rst_ni,
              (pop && push_i.cnt == 2'd0) |=> (count_q == $past(count_q) - lme_pkg::CntW'(1)))

endmodule

// File: sv/lsb_message_extractor.sv
// A result is queued when its input beat is accepted and is offered from the queue head.
// Throughput: one input beat per cycle while input ready is high; the output sends one
// result per cycle when ready; a four-entry queue buffers beats that yield two results.
// Input ready drops while fewer than two queue entries are free.
// Reset (async, active low) rearms the decoder and empties the queue.
`include "lsb_message_extractor_defines.svh"

module lsb_message_extractor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] char_value_o,
  output logic [1:0] status_o,
  output logic       run_end_o
);

  typedef enum logic [1:0] {
    PhMsg   = 2'd0,
    PhCheck = 2'd1,
    PhDone  = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  bit_count_q, bit_count_d;
  logic [7:0]  char_shift_q, char_shift_d;
  logic [31:0] running_check_q, running_check_d;
  logic [31:0] committed_check_q, committed_check_d;
  logic [31:0] received_check_q, received_check_d;
  logic        seen_char_q, seen_char_d;

  logic             in_fire;
  logic             msg_bit;
  logic [7:0]       shift_nxt;
  logic [31:0]      check_nxt;
  logic [31:0]      recv_nxt;
  logic             r0_vld, r1_vld, status_out;
  lme_pkg::result_t r0, r1, head;
  lme_pkg::push_t   push;

  function automatic logic [31:0] check_bit(logic [31:0] c, logic b);
    logic [31:0] v;
    v = c ^ {b, 31'd0};
    for (int k = 0; k < lme_pkg::CheckSteps; k++) begin
      v = v[31] ? ({v[30:0], 1'b0} ^ lme_pkg::CheckPoly) : {v[30:0], 1'b0};
    end
    return v;
  endfunction

  assign in_fire   = in_valid_i && in_ready_o;
  assign msg_bit   = pixel_byte_i[0];
  assign shift_nxt = {char_shift_q[6:0], msg_bit};
  assign check_nxt = check_bit(running_check_q, msg_bit);
  assign recv_nxt  = {received_check_q[30:0], msg_bit};

  always_comb begin
    phase_d           = phase_q;
    bit_count_d       = bit_count_q;
    char_shift_d      = char_shift_q;
    running_check_d   = running_check_q;
    committed_check_d = committed_check_q;
    received_check_d  = received_check_q;
    seen_char_d       = seen_char_q;
    r0_vld            = 1'b0;
    r1_vld            = 1'b0;
    status_out        = 1'b0;
    r0                = '{kind: lme_pkg::KindChar, char_value: 8'd0,
                          status: lme_pkg::StOk, run_end: 1'b0};
    r1                = '{kind: lme_pkg::KindStatus, char_value: 8'd0,
                          status: lme_pkg::StNoMsg, run_end: 1'b0};

    if (in_fire) begin
      unique case (phase_q)
        PhMsg: begin
          char_shift_d    = shift_nxt;
          running_check_d = check_nxt;
          bit_count_d     = bit_count_q + 5'd1;
          if (bit_count_q == lme_pkg::CharLastBit) begin
            bit_count_d  = '0;
            char_shift_d = '0;
            if (shift_nxt == 8'd0) begin
              // terminator bits never enter the check
              running_check_d = committed_check_q;
              phase_d         = PhCheck;
            end else begin
              committed_check_d = check_nxt;
              seen_char_d       = 1'b1;
              r0_vld            = 1'b1;
              r0.char_value     = shift_nxt;
            end
          end
        end
        PhCheck: begin
          received_check_d = recv_nxt;
          bit_count_d      = bit_count_q + 5'd1;
          if (bit_count_q == lme_pkg::CheckLastBit) begin
            bit_count_d = '0;
            phase_d     = PhDone;
            status_out  = 1'b1;
            r0_vld      = 1'b1;
            r0.kind     = lme_pkg::KindStatus;
            if (recv_nxt != committed_check_q) begin
              r0.status = lme_pkg::StBadCheck;
            end else if (!seen_char_q) begin
              r0.status = lme_pkg::StNoMsg;
            end else begin
              r0.status = lme_pkg::StOk;
            end
          end
        end
        default: begin
          // done: drop the beat
        end
      endcase

      if (is_last_i) begin
        r1_vld            = !status_out && (phase_d == PhMsg || phase_d == PhCheck);
        phase_d           = PhMsg;
        bit_count_d       = '0;
        char_shift_d      = '0;
        running_check_d   = lme_pkg::CheckInit;
        committed_check_d = lme_pkg::CheckInit;
        received_check_d  = '0;
        seen_char_d       = 1'b0;
      end
    end

    // pack results toward the first slot, flag the last one
    r0.run_end  = !r1_vld;
    r1.run_end  = 1'b1;
    push.cnt    = 2'(r0_vld) + 2'(r1_vld);
    push.first  = r0_vld ? r0 : r1;
    push.second = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PhMsg;
      bit_count_q       <= '0;
      char_shift_q      <= '0;
      running_check_q   <= lme_pkg::CheckInit;
      committed_check_q <= lme_pkg::CheckInit;
      received_check_q  <= '0;
      seen_char_q       <= 1'b0;
    end else begin
      phase_q           <= phase_d;
      bit_count_q       <= bit_count_d;
      char_shift_q      <= char_shift_d;
      running_check_q   <= running_check_d;
      committed_check_q <= committed_check_d;
      received_check_q  <= received_check_d;
      seen_char_q       <= seen_char_d;
    end
  end

  lme_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o       = head.kind;
  assign char_value_o = head.char_value;
  assign status_o     = head.status;
  assign run_end_o    = head.run_end;

  `LME_ASSERT(a_check_shift_clear, clk_i, rst_ni,
              (phase_q == PhCheck) |-> (char_shift_q == 8'd0))
  `LME_ASSERT(a_msg_count_range, clk_i, rst_ni,
              (phase_q == PhMsg) |-> (bit_count_q <= lme_pkg::CharLastBit))
  `LME_ASSERT(a_last_rearms, clk_i, rst_ni,
              (in_fire && is_last_i) |=> (phase_q == PhMsg && bit_count_q == 5'd0 &&
                                          !seen_char_q))

endmodule
